// File: src/mav_pkg.sv
// ----------------------------------------------------------------------------
// mav_pkg
// Shared constants, types and helpers for the three-axis moving average core.
// ----------------------------------------------------------------------------
package mav_pkg;

    localparam int AXES       = 3;
    localparam int WINDOW_MAX = 64;
    localparam int SAMPLE_W   = 32;
    localparam int CFG_W      = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int IDX_W      = $clog2(WINDOW_MAX);
    localparam int WIN_W      = $clog2(WINDOW_MAX + 1);
    localparam int SUM_W      = SAMPLE_W + IDX_W;
    localparam int CNT_W      = $clog2(SUM_W + 1);

    localparam logic [CFG_W-1:0] WINDOW_RESET = CFG_W'(8);

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_X = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_Y = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_Z = CFG_IDX_W'(2);

    typedef struct packed {
        logic capture;   // input beat taken: latch samples, read ring
        logic update;    // fold new sample into sum, write ring
        logic start;     // launch dividers
        logic load_out;  // move quotients into output register
        logic cfg_we;    // config write
    } t_dp_cmd;

    typedef struct packed {
        logic div_done;
    } t_dp_sts;

    // zero acts as one, anything above the ring depth saturates
    function automatic logic [WIN_W-1:0] eff_window(input logic [CFG_W-1:0] raw);
        logic [WIN_W-1:0] w;
        if (raw == '0) begin
            w = WIN_W'(1);
        end else if (int'(raw) > WINDOW_MAX) begin
            w = WIN_W'(WINDOW_MAX);
        end else begin
            w = WIN_W'(raw);
        end
        return w;
    endfunction

endpackage

// File: src/mav_ram.sv
// ----------------------------------------------------------------------------
// mav_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mav_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/mav_div.sv
// ----------------------------------------------------------------------------
// mav_div
// Radix-2 restoring divider: signed running sum by unsigned window length.
// Returns quotient magnitude and sign; one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mav_div
    import mav_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [SUM_W-1:0] i_dividend,
    input  logic [WIN_W-1:0]        i_divisor,
    output logic                    o_busy,
    output logic [SUM_W-1:0]        o_quotient,
    output logic                    o_neg
);

    logic [SUM_W-1:0] r_quo;
    logic [WIN_W-1:0] r_rem;
    logic [WIN_W-1:0] r_den;
    logic             r_neg;
    logic [CNT_W-1:0] r_cnt;

    logic [WIN_W:0]   trial;
    logic             fits;
    logic [WIN_W:0]   n_rem;
    logic [SUM_W-1:0] magnitude;

    assign magnitude = i_dividend[SUM_W-1] ? SUM_W'(-i_dividend) : SUM_W'(i_dividend);

    always_comb begin
        trial = {r_rem, r_quo[SUM_W-1]};
        fits  = (trial >= {1'b0, r_den});
        n_rem = fits ? (trial - {1'b0, r_den}) : trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CNT_W'(SUM_W);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= magnitude;
            r_rem <= '0;
            r_den <= i_divisor;
            r_neg <= i_dividend[SUM_W-1];
        end else if (r_cnt != '0) begin
            r_quo <= {r_quo[SUM_W-2:0], fits};
            r_rem <= n_rem[WIN_W-1:0];
        end
    end

    assign o_busy     = (r_cnt != '0);
    assign o_quotient = r_quo;
    assign o_neg      = r_neg;

endmodule

// File: src/mav_dp.sv
// ----------------------------------------------------------------------------
// mav_dp
// Datapath: per-axis window register, sample ring, running sum, divider and
// output register.
// ----------------------------------------------------------------------------
module mav_dp
    import mav_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_dp_cmd                    i_cmd,
    output t_dp_sts                    o_sts,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [CFG_W-1:0]           i_cfg_data,
    input  logic signed [SAMPLE_W-1:0] i_sample_x,
    input  logic signed [SAMPLE_W-1:0] i_sample_y,
    input  logic signed [SAMPLE_W-1:0] i_sample_z,
    output logic signed [SAMPLE_W-1:0] o_mean_x,
    output logic signed [SAMPLE_W-1:0] o_mean_y,
    output logic signed [SAMPLE_W-1:0] o_mean_z
);

    logic [AXES-1:0][SAMPLE_W-1:0] sample_in;
    logic [AXES-1:0][SAMPLE_W-1:0] mean_all;
    logic [AXES-1:0]               div_busy;
    logic [AXES-1:0]               cfg_sel;

    assign sample_in[0] = i_sample_x;
    assign sample_in[1] = i_sample_y;
    assign sample_in[2] = i_sample_z;

    always_comb begin
        cfg_sel = '0;
        if (i_cmd.cfg_we) begin
            unique case (i_cfg_index)
                REG_WINDOW_X: cfg_sel[0] = 1'b1;
                REG_WINDOW_Y: cfg_sel[1] = 1'b1;
                REG_WINDOW_Z: cfg_sel[2] = 1'b1;
                default:      cfg_sel    = '0;
            endcase
        end
    end

    for (genvar a = 0; a < AXES; a++) begin : g_axis
        logic [CFG_W-1:0]           r_window;
        logic [IDX_W-1:0]           r_slot;
        logic [IDX_W-1:0]           r_rd_slot;
        logic [WINDOW_MAX-1:0]      r_valid;
        logic signed [SUM_W-1:0]    r_sum;
        logic signed [SAMPLE_W-1:0] r_sample;
        logic [SAMPLE_W-1:0]        r_mean;

        logic [WIN_W-1:0]           w_eff;
        logic [WIN_W-1:0]           slot_inc;
        logic [IDX_W-1:0]           cur_slot;
        logic [IDX_W-1:0]           nxt_slot;
        logic [SAMPLE_W-1:0]        rdata;
        logic signed [SAMPLE_W-1:0] old;
        logic signed [SUM_W-1:0]    n_sum;
        logic [SUM_W-1:0]           quo;
        logic                       neg;

        assign w_eff    = eff_window(r_window);
        assign cur_slot = (WIN_W'(r_slot) >= w_eff) ? '0 : r_slot;
        assign slot_inc = WIN_W'(r_rd_slot) + WIN_W'(1);
        assign nxt_slot = (slot_inc >= w_eff) ? '0 : IDX_W'(slot_inc);
        // slot never written since reset or restart reads as zero
        assign old      = r_valid[r_rd_slot] ? $signed(rdata) : '0;
        assign n_sum    = r_sum + SUM_W'(r_sample) - SUM_W'(old);

        mav_ram #(
            .WIDTH (SAMPLE_W),
            .DEPTH (WINDOW_MAX)
        ) u_ring (
            .i_clk   (i_clk),
            .i_we    (i_cmd.update),
            .i_waddr (r_rd_slot),
            .i_wdata (r_sample),
            .i_re    (i_cmd.capture),
            .i_raddr (cur_slot),
            .o_rdata (rdata)
        );

        mav_div u_div (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_start    (i_cmd.start),
            .i_dividend (r_sum),
            .i_divisor  (w_eff),
            .o_busy     (div_busy[a]),
            .o_quotient (quo),
            .o_neg      (neg)
        );

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_window <= WINDOW_RESET;
                r_slot   <= '0;
                r_valid  <= '0;
                r_sum    <= '0;
            end else if (cfg_sel[a]) begin
                // any window write restarts the axis
                r_window <= i_cfg_data;
                r_slot   <= '0;
                r_valid  <= '0;
                r_sum    <= '0;
            end else if (i_cmd.update) begin
                r_sum              <= n_sum;
                r_valid[r_rd_slot] <= 1'b1;
                r_slot             <= nxt_slot;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_cmd.capture) begin
                r_sample  <= sample_in[a];
                r_rd_slot <= cur_slot;
            end
            if (i_cmd.load_out) begin
                r_mean <= neg ? (-quo[SAMPLE_W-1:0]) : quo[SAMPLE_W-1:0];
            end
        end

        assign mean_all[a] = r_mean;
    end

    assign o_sts.div_done = ~|div_busy;

    assign o_mean_x = mean_all[0];
    assign o_mean_y = mean_all[1];
    assign o_mean_z = mean_all[2];

endmodule

// File: src/mav_ctrl.sv
// ----------------------------------------------------------------------------
// mav_ctrl
// Controller: sequences one beat through ring update and division, and owns
// the input stall, output valid and config ready.
// ----------------------------------------------------------------------------
module mav_ctrl
    import mav_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_stall,
    output logic    o_valid,
    input  logic    i_stall,
    input  logic    i_cfg_valid,
    output logic    o_cfg_ready,
    output t_dp_cmd o_cmd,
    input  t_dp_sts i_sts
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_UPDATE,
        S_START,
        S_DIV,
        S_DONE
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || !i_stall;

    always_comb begin
        o_cmd          = '0;
        o_cmd.capture  = (r_state == S_IDLE) && i_valid;
        o_cmd.update   = (r_state == S_UPDATE);
        o_cmd.start    = (r_state == S_START);
        o_cmd.load_out = (r_state == S_DONE) && out_free;
        o_cmd.cfg_we   = (r_state == S_IDLE) && i_cfg_valid && !i_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE:   if (i_valid) r_state <= S_UPDATE;
                S_UPDATE: r_state <= S_START;
                S_START:  r_state <= S_DIV;
                S_DIV:    if (i_sts.div_done) r_state <= S_DONE;
                S_DONE:   if (out_free) r_state <= S_IDLE;
                default:  r_state <= S_IDLE;
            endcase

            if (o_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stall     = (r_state != S_IDLE);
    assign o_valid     = r_out_valid;
    // a sample beat offered in the same cycle goes first
    assign o_cfg_ready = (r_state == S_IDLE) && !i_valid;

endmodule

// File: src/three_axis_moving_average_core.sv
// ----------------------------------------------------------------------------
// three_axis_moving_average_core
// Per-axis moving average over a ring of recent Q16.16 samples, with
// configurable window length per axis and a running sum divided by it.
// ----------------------------------------------------------------------------
//  channel  | handshake                | payload
//  ---------+--------------------------+-------------------------------------
//  input    | i_valid / o_stall        | i_sample_x, i_sample_y, i_sample_z
//  output   | o_valid / i_stall        | o_mean_x, o_mean_y, o_mean_z
//  config   | i_cfg_valid / o_cfg_ready| i_cfg_index, i_cfg_data
//
//  One beat at a time: each accepted beat passes through the ring update and the
//  38-step restoring divider (one quotient bit per cycle, three axes in parallel).
//  The next beat is taken as soon as the result sits in the output register,
//  so a stalled output only holds the block once a second result is ready.
//  Synchronous active-low reset clears the rings (per-slot valid bits), sums,
//  slots and sets every window to 8; a window write restarts that axis.
// ----------------------------------------------------------------------------
module three_axis_moving_average_core
    import mav_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic signed [SAMPLE_W-1:0] i_sample_x,
    input  logic signed [SAMPLE_W-1:0] i_sample_y,
    input  logic signed [SAMPLE_W-1:0] i_sample_z,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic signed [SAMPLE_W-1:0] o_mean_x,
    output logic signed [SAMPLE_W-1:0] o_mean_y,
    output logic signed [SAMPLE_W-1:0] o_mean_z,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [CFG_W-1:0]           i_cfg_data
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    mav_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    mav_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_sample_x  (i_sample_x),
        .i_sample_y  (i_sample_y),
        .i_sample_z  (i_sample_z),
        .o_mean_x    (o_mean_x),
        .o_mean_y    (o_mean_y),
        .o_mean_z    (o_mean_z)
    );

endmodule

// File: src/mav_chk.sv
// ----------------------------------------------------------------------------
// mav_chk
// Port-level checks for the moving average core, bound to the top level.
// ----------------------------------------------------------------------------
module mav_chk
    import mav_pkg::*;
(
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_valid,
    input logic                       o_stall,
    input logic                       o_valid,
    input logic                       i_stall,
    input logic signed [SAMPLE_W-1:0] o_mean_x,
    input logic signed [SAMPLE_W-1:0] o_mean_y,
    input logic signed [SAMPLE_W-1:0] o_mean_z,
    input logic                       o_cfg_ready
);

    // an accepted beat keeps the input stalled while it is worked on
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input not stalled after accepted beat");

    // no result can appear in the cycle after a beat is taken
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> !$rose(o_valid))
        else $error("result rose right after accept");

    // config is only taken while no beat is in flight
    a_cfg_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready |-> !o_stall)
        else $error("config ready while busy");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_mean_x)
                                  && $stable(o_mean_y) && $stable(o_mean_z)))
        else $error("stalled output beat changed");

endmodule

bind three_axis_moving_average_core mav_chk u_mav_chk (.*);

// File: dv/three_axis_moving_average_checker.sv
// ----------------------------------------------------------------------------
// three_axis_moving_average_checker
// Watches the sample, mean and window-register channels of the moving average
// core, keeps its own per-axis rings and running sums, and compares each
// output beat against the oldest predicted triple of means.
// ----------------------------------------------------------------------------
module three_axis_moving_average_checker
    import mav_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  logic [SAMPLE_W-1:0]  i_sample_x,
    input  logic [SAMPLE_W-1:0]  i_sample_y,
    input  logic [SAMPLE_W-1:0]  i_sample_z,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  logic [SAMPLE_W-1:0]  i_mean_x,
    input  logic [SAMPLE_W-1:0]  i_mean_y,
    input  logic [SAMPLE_W-1:0]  i_mean_z,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output int                   o_fail_count,
    output int                   o_pending,
    output int                   o_checked
);

    typedef logic [AXES-1:0][SAMPLE_W-1:0] t_means;

    logic signed [SAMPLE_W-1:0] ring [AXES][WINDOW_MAX];
    longint                     sum_acc [AXES];
    int                         head [AXES];
    logic [CFG_W-1:0]           win_raw [AXES];
    t_means                     means_due [$];
    string                      axis_tag [AXES] = '{"x", "y", "z"};

    task automatic flag_mismatch(input string msg);
        $display("%0t: mismatch: %s", $time, msg);
        o_fail_count++;
    endtask

    function automatic int window_len(input logic [CFG_W-1:0] raw);
        if (raw == '0) return 1;
        if (int'(raw) > WINDOW_MAX) return WINDOW_MAX;
        return int'(raw);
    endfunction

    task automatic restart_axis(input int a);
        for (int k = 0; k < WINDOW_MAX; k++) ring[a][k] = '0;
        sum_acc[a] = 0;
        head[a]    = 0;
    endtask

    // newest sample overwrites the oldest slot; mean truncates toward zero
    task automatic advance_windows(input t_means s, output t_means m);
        int len;
        int pos;
        longint q;
        logic signed [SAMPLE_W-1:0] smp;
        for (int a = 0; a < AXES; a++) begin
            len = window_len(win_raw[a]);
            pos = head[a];
            if (pos >= len) pos = 0;
            smp = s[a];
            sum_acc[a] += longint'(smp) - longint'(ring[a][pos]);
            ring[a][pos] = smp;
            pos++;
            if (pos >= len) pos = 0;
            head[a] = pos;
            q = sum_acc[a] / longint'(len);
            m[a] = q[SAMPLE_W-1:0];
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_means got;
        t_means want;
        t_means beat;
        if (!i_rst_n) begin
            for (int a = 0; a < AXES; a++) begin
                win_raw[a] = WINDOW_RESET;
                restart_axis(a);
            end
            means_due.delete();
            o_fail_count = 0;
            o_checked    = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_WINDOW_X: begin
                        win_raw[0] = i_cfg_data;
                        restart_axis(0);
                    end
                    REG_WINDOW_Y: begin
                        win_raw[1] = i_cfg_data;
                        restart_axis(1);
                    end
                    REG_WINDOW_Z: begin
                        win_raw[2] = i_cfg_data;
                        restart_axis(2);
                    end
                    default: ;
                endcase
            end
            // retire before predicting, so a same-edge beat never matches itself
            if (i_out_valid && !i_out_stall) begin
                got = {i_mean_z, i_mean_y, i_mean_x};
                if (means_due.size() == 0) begin
                    flag_mismatch($sformatf("mean beat %h with nothing outstanding", got));
                end else begin
                    want = means_due.pop_front();
                    for (int a = 0; a < AXES; a++) begin
                        if (got[a] !== want[a]) begin
                            flag_mismatch($sformatf("mean_%s got %h want %h (beat %0d)",
                                axis_tag[a], got[a], want[a], o_checked));
                        end
                    end
                    o_checked++;
                end
            end
            if (i_in_valid && !i_in_stall) begin
                beat = {i_sample_z, i_sample_y, i_sample_x};
                advance_windows(beat, want);
                means_due.push_back(want);
            end
        end
        o_pending = means_due.size();
    end

endmodule

// File: dv/three_axis_moving_average_core_tb.sv
// ----------------------------------------------------------------------------
// three_axis_moving_average_core_tb
// Drives three-axis Q16.16 samples and window settings into the moving average
// core with random gaps and output back-pressure; a separate checker predicts
// every mean triple and this top reports the verdict.
// ----------------------------------------------------------------------------
module three_axis_moving_average_core_tb;
    import mav_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(3);
    localparam logic [SAMPLE_W-1:0]  Q_MAX      = 32'h7fff_ffff;
    localparam logic [SAMPLE_W-1:0]  Q_MIN      = 32'h8000_0000;
    localparam int PHASES     = 8;
    localparam int PER_PHASE  = 244;
    localparam int LONG_HOLD  = 300;
    localparam int DRAIN_WAIT = 60;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [SAMPLE_W-1:0]  smp_x = '0;
    logic [SAMPLE_W-1:0]  smp_y = '0;
    logic [SAMPLE_W-1:0]  smp_z = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [SAMPLE_W-1:0]  mean_x;
    logic [SAMPLE_W-1:0]  mean_y;
    logic [SAMPLE_W-1:0]  mean_z;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;

    logic in_taken = 1'b0;
    logic out_taken = 1'b0;
    logic cfg_taken = 1'b0;
    logic tight = 1'b0;      // no gaps on either side
    logic hold_req = 1'b0;   // receiver: one long back-pressure stretch

    int fail_count;
    int pending;
    int checked;
    int n_sent = 0;
    int n_writes = 0;

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    three_axis_moving_average_core uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_valid     (in_valid),
        .o_stall     (in_stall),
        .i_sample_x  (smp_x),
        .i_sample_y  (smp_y),
        .i_sample_z  (smp_z),
        .o_valid     (out_valid),
        .i_stall     (out_stall),
        .o_mean_x    (mean_x),
        .o_mean_y    (mean_y),
        .o_mean_z    (mean_z),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    three_axis_moving_average_checker avg_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_sample_x   (smp_x),
        .i_sample_y   (smp_y),
        .i_sample_z   (smp_z),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_mean_x     (mean_x),
        .i_mean_y     (mean_y),
        .i_mean_z     (mean_z),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    // handshake outcomes, read back at the falling edge
    always @(posedge clk) begin
        in_taken  <= in_valid && !in_stall;
        out_taken <= out_valid && !out_stall;
        cfg_taken <= cfg_valid && cfg_ready;
    end

    task automatic send_sample(input logic [SAMPLE_W-1:0] x, y, z);
        int gap;
        gap = tight ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        smp_x = x;
        smp_y = y;
        smp_z = z;
        do @(negedge clk); while (!in_taken);
        n_sent++;
    endtask

    // stop offering and wait for every outstanding mean
    task automatic settle();
        in_valid = 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    task automatic write_window(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_W-1:0] val);
        settle();
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        do @(negedge clk); while (!cfg_taken);
        cfg_valid = 1'b0;
        n_writes++;
        @(negedge clk);
    endtask

    function automatic logic [SAMPLE_W-1:0] random_sample();
        int pick;
        pick = $urandom_range(0, 9);
        case (pick)
            0:       return Q_MAX;
            1:       return Q_MIN;
            2, 3, 4: return SAMPLE_W'($urandom_range(0, 131071)) - SAMPLE_W'(65536);
            default: return $urandom;
        endcase
    endfunction

    // receiver: random stall per beat, plus one long hold on request
    initial begin : receiver
        int w;
        while (!rst_n) @(negedge clk);
        forever begin
            if (hold_req) begin
                out_stall = 1'b1;
                repeat (LONG_HOLD) @(negedge clk);
                hold_req = 1'b0;
            end
            w = tight ? 0 : $urandom_range(0, 5);
            if (w > 0) begin
                out_stall = 1'b1;
                repeat (w) @(negedge clk);
            end
            out_stall = 1'b0;
            do @(negedge clk); while (!out_taken);
        end
    end

    initial begin : stimulus
        logic [CFG_W-1:0] wins [PHASES][AXES];
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset windows of 8, field extremes
        send_sample(Q_MAX, Q_MIN, '0);
        send_sample(Q_MIN, Q_MAX, '1);
        send_sample(32'd1, '1, Q_MAX);
        send_sample('0, '0, Q_MIN);

        // shortest, longest, and zero (acts as one)
        write_window(REG_WINDOW_X, 7'd1);
        write_window(REG_WINDOW_Y, 7'd64);
        write_window(REG_WINDOW_Z, 7'd0);
        for (int k = 0; k < 6; k++) begin
            send_sample(k[0] ? Q_MIN : Q_MAX, k[0] ? Q_MIN : Q_MAX, k[0] ? Q_MAX : Q_MIN);
        end

        // above the ring depth saturates; unused index must change nothing
        write_window(REG_WINDOW_X, 7'd127);
        write_window(REG_WINDOW_Y, 7'd65);
        write_window(REG_WINDOW_Z, 7'd64);
        send_sample('1, '1, '1);
        send_sample(Q_MIN, Q_MIN, Q_MIN);
        write_window(REG_UNUSED, 7'h55);
        send_sample(Q_MAX, Q_MAX, Q_MAX);
        send_sample(32'd1, 32'd2, 32'd3);
        send_sample(-32'sd2, -32'sd3, -32'sd5);

        // rewriting the same value still restarts that axis only
        write_window(REG_WINDOW_X, 7'd127);
        send_sample(32'h0001_0000, 32'hffff_0000, 32'h0000_8000);
        write_window(REG_WINDOW_Y, 7'd65);
        send_sample(32'h0002_0000, 32'hfffe_0000, 32'h0000_8000);
        send_sample(Q_MIN, Q_MAX, '0);

        wins[0] = '{7'd1, 7'd1, 7'd1};
        wins[1] = '{7'd64, 7'd64, 7'd64};
        wins[2] = '{7'd0, 7'd127, 7'd65};
        wins[3] = '{7'd2, 7'd3, 7'd5};
        wins[4] = '{7'd8, 7'd8, 7'd8};
        wins[5] = '{7'd63, 7'd1, 7'd64};
        for (int p = 6; p < PHASES; p++) begin
            for (int a = 0; a < AXES; a++) wins[p][a] = CFG_W'($urandom_range(0, 127));
        end

        for (int p = 0; p < PHASES; p++) begin
            write_window(REG_WINDOW_X, wins[p][0]);
            write_window(REG_WINDOW_Y, wins[p][1]);
            write_window(REG_WINDOW_Z, wins[p][2]);
            if (p % 3 == 0) write_window(REG_UNUSED, CFG_W'($urandom_range(0, 127)));
            tight = (p == 3);
            for (int i = 0; i < PER_PHASE; i++) begin
                if (p == 2 && i == 40) begin
                    // long receiver hold while beats keep coming: block backs up
                    hold_req = 1'b1;
                    tight = 1'b1;
                end
                if (p == 2 && i == 80) tight = 1'b0;
                if (p == 5 && i == 120) settle();
                send_sample(random_sample(), random_sample(), random_sample());
            end
        end
        tight = 1'b0;

        settle();
        repeat (DRAIN_WAIT) @(negedge clk);

        $display("Run covered %0d sample beats and %0d checked means over %0d window writes,",
            n_sent, checked, n_writes);
        $display("with windows from 0 through 127, ignored register index, and a long output hold.");
        if (fail_count == 0 && pending == 0) begin
            $display("[three_axis_moving_average_core] OK");
        end else begin
            $display("[three_axis_moving_average_core] ERROR");
        end
        $finish;
    end

    initial begin : watchdog
        #12_000_000;
        $display("[three_axis_moving_average_core] ERROR");
        $finish;
    end

endmodule
